// ===== rtl/wsfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package wsfd_pkg;

  typedef enum logic [2:0] {
    PH_HEAD = 3'd0,
    PH_LEN  = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4,
    PH_DEAD = 3'd5
  } phase_t;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_DATA  = 2'd0;
  localparam kind_t KIND_EMPTY = 2'd1;
  localparam kind_t KIND_BAD   = 2'd2;
  localparam kind_t KIND_CLOSE = 2'd3;

  // First header byte: FIN set, reserved bits clear.
  localparam logic [3:0] HDR_TOP   = 4'h8;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

endpackage
`default_nettype wire

// ===== rtl/wsfd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface wsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsfd_out_if;
  import wsfd_pkg::*;
  logic       valid;
  logic       ready;
  kind_t      kind;
  logic [7:0] payload_byte;
  logic [3:0] frame_opcode;
  logic       last;

  modport source (output valid, output kind, output payload_byte, output frame_opcode,
                  output last, input ready);
  modport sink (input valid, input kind, input payload_byte, input frame_opcode,
                input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/websocket_frame_deframer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// WebSocket receive-side deframer.
// in_chan carries the received stream, one byte per request (valid/ready).
// out_chan carries results: payload bytes, unmasked with the frame's key if masked, one
// empty-frame result per frame with no payload, and a bad-header or close
// event. last marks the final payload byte and every event.
// Header bytes give no result; the byte that completes a header of an empty
// frame gives the empty-frame result.
// Each byte is parsed in the cycle it is accepted and its result sits in the
// output register on the next cycle; throughput is 1 byte per cycle while the
// receiver takes results. The rate is set by parsing each byte as it is accepted,
// with a 64-bit length down-counter and the one-entry output register.
// When the receiver stalls, in_chan.ready drops while a result is held; it
// stays high in the cycle the held result is taken.
// After a bad header or a close the block swallows every byte with no result
// until reset. Synchronous reset (rst_n low) returns the parser to waiting
// for a first header byte and empties the output register.
module websocket_frame_deframer_top (
  input  wire         clk,
  input  wire         rst_n,
  wsfd_in_if.sink     in_chan,
  wsfd_out_if.source  out_chan
);
  import wsfd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  opcode_r, opcode_nxt;
  logic        masked_r, masked_nxt;
  logic [3:0]  ext_left_r, ext_left_nxt;
  logic [63:0] bytes_left_r, bytes_left_nxt;
  logic [31:0] mask_key_r, mask_key_nxt;
  logic [1:0]  key_idx_r, key_idx_nxt;

  logic        out_valid_r;
  kind_t       kind_r, kind_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [3:0]  op_out_r, op_out_nxt;
  logic        last_r, last_nxt;
  logic        emit;

  logic        accept;
  logic [7:0]  b;
  logic        hdr_bad, hdr_close, len_is_ext, len7_zero;
  logic [63:0] ext_shift;
  logic        ext_done, ext_zero, key_done, data_fin;
  logic [1:0]  key_idx_inc;
  logic [7:0]  key_byte;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign b             = in_chan.rx_byte;

  assign hdr_bad     = b[7:4] != HDR_TOP;
  assign hdr_close   = b[3:0] == OP_CLOSE;
  assign len_is_ext  = (b[6:0] == LEN_EXT16) || (b[6:0] == LEN_EXT64);
  assign len7_zero   = b[6:0] == 7'd0;
  assign ext_shift   = {bytes_left_r[55:0], b};
  assign ext_done    = ext_left_r == 4'd1;
  assign ext_zero    = ext_shift == 64'd0;
  assign key_idx_inc = key_idx_r + 2'd1;
  assign key_done    = key_idx_inc == 2'd0;
  assign data_fin    = bytes_left_r == 64'd1;

  always_comb begin
    case (key_idx_r)
      2'd0:    key_byte = mask_key_r[31:24];
      2'd1:    key_byte = mask_key_r[23:16];
      2'd2:    key_byte = mask_key_r[15:8];
      default: key_byte = mask_key_r[7:0];
    endcase
  end

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_HEAD: begin
        if (hdr_bad || hdr_close) phase_nxt = PH_DEAD;
        else phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        if (len_is_ext) phase_nxt = PH_EXT;
        else if (b[7]) phase_nxt = PH_KEY;
        else if (len7_zero) phase_nxt = PH_HEAD;
        else phase_nxt = PH_DATA;
      end
      PH_EXT: begin
        if (ext_done) begin
          if (masked_r) phase_nxt = PH_KEY;
          else if (ext_zero) phase_nxt = PH_HEAD;
          else phase_nxt = PH_DATA;
        end
      end
      PH_KEY: begin
        if (key_done) begin
          if (bytes_left_r == 64'd0) phase_nxt = PH_HEAD;
          else phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        if (data_fin) phase_nxt = PH_HEAD;
      end
      default: phase_nxt = PH_DEAD;
    endcase
  end

  // Datapath registers and result.
  always_comb begin
    opcode_nxt     = opcode_r;
    masked_nxt     = masked_r;
    ext_left_nxt   = ext_left_r;
    bytes_left_nxt = bytes_left_r;
    mask_key_nxt   = mask_key_r;
    key_idx_nxt    = key_idx_r;
    emit           = 1'b0;
    kind_nxt       = KIND_DATA;
    data_nxt       = 8'd0;
    op_out_nxt     = opcode_r;
    last_nxt       = 1'b1;
    case (phase_r)
      PH_HEAD: begin
        op_out_nxt = b[3:0];
        if (hdr_bad) begin
          emit     = 1'b1;
          kind_nxt = KIND_BAD;
        end else if (hdr_close) begin
          emit     = 1'b1;
          kind_nxt = KIND_CLOSE;
        end else begin
          opcode_nxt = b[3:0];
        end
      end
      PH_LEN: begin
        masked_nxt  = b[7];
        key_idx_nxt = 2'd0;
        if (len_is_ext) begin
          ext_left_nxt   = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          bytes_left_nxt = 64'd0;
        end else begin
          bytes_left_nxt = {57'd0, b[6:0]};
          if (!b[7] && len7_zero) begin
            emit     = 1'b1;
            kind_nxt = KIND_EMPTY;
          end
        end
      end
      PH_EXT: begin
        bytes_left_nxt = ext_shift;
        ext_left_nxt   = ext_left_r - 4'd1;
        if (ext_done) begin
          key_idx_nxt = 2'd0;
          if (!masked_r && ext_zero) begin
            emit     = 1'b1;
            kind_nxt = KIND_EMPTY;
          end
        end
      end
      PH_KEY: begin
        mask_key_nxt = {mask_key_r[23:0], b};
        key_idx_nxt  = key_idx_inc;
        if (key_done && bytes_left_r == 64'd0) begin
          emit     = 1'b1;
          kind_nxt = KIND_EMPTY;
        end
      end
      PH_DATA: begin
        key_idx_nxt    = key_idx_inc;
        bytes_left_nxt = bytes_left_r - 64'd1;
        emit           = 1'b1;
        kind_nxt       = KIND_DATA;
        data_nxt       = masked_r ? (b ^ key_byte) : b;
        last_nxt       = data_fin;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEAD;
      opcode_r     <= 4'd0;
      masked_r     <= 1'b0;
      ext_left_r   <= 4'd0;
      bytes_left_r <= 64'd0;
      mask_key_r   <= 32'd0;
      key_idx_r    <= 2'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        phase_r      <= phase_nxt;
        opcode_r     <= opcode_nxt;
        masked_r     <= masked_nxt;
        ext_left_r   <= ext_left_nxt;
        bytes_left_r <= bytes_left_nxt;
        mask_key_r   <= mask_key_nxt;
        key_idx_r    <= key_idx_nxt;
        out_valid_r  <= emit;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      kind_r   <= kind_nxt;
      data_r   <= data_nxt;
      op_out_r <= op_out_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.kind         = kind_r;
  assign out_chan.payload_byte = data_r;
  assign out_chan.frame_opcode = op_out_r;
  assign out_chan.last         = last_r;

  // Once an event has been reported, nothing but reset leaves the dropping phase.
  a_dead_holds: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DEAD |=> phase_r == PH_DEAD)
    else $error("left dropping phase without reset");

  // A bad first header byte must produce a bad-header event on the next cycle.
  a_bad_reported: assert property (@(posedge clk) disable iff (!rst_n)
    accept && phase_r == PH_HEAD && hdr_bad |=> out_valid_r && kind_r == KIND_BAD)
    else $error("bad header not reported");

  // Events always carry last and a zero payload byte.
  a_event_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r != KIND_DATA |-> last_r && data_r == 8'd0)
    else $error("event result malformed");

  // The payload phase is never entered or kept with no bytes left.
  a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DATA |-> bytes_left_r != 64'd0)
    else $error("payload phase with zero count");

endmodule
`default_nettype wire

// ===== sim/tb_websocket_frame_deframer_top.sv =====
`timescale 1ns / 1ps
module tb_websocket_frame_deframer_top;
  import wsfd_pkg::*;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload;
    logic [3:0] opcode;
    logic       last;
  } frame_result_t;

  typedef struct packed {
    logic [7:0]    rx;
    logic          typed;
    frame_result_t want;
  } stim_row_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DIRECTED_ROWS = 21;
  localparam int STREAM_BYTES = 1950;
  localparam frame_result_t NO_TYPED = '0;

  // Rows with typed set carry their expected result; the rest go through the parser model.
  stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
    {8'h81, 1'b0, NO_TYPED},
    {8'h00, 1'b1, KIND_EMPTY, 8'h00, 4'h1, 1'b1},
    {8'h8f, 1'b0, NO_TYPED},
    {8'h80, 1'b0, NO_TYPED},
    {8'ha5, 1'b0, NO_TYPED},
    {8'h5a, 1'b0, NO_TYPED},
    {8'h3c, 1'b0, NO_TYPED},
    {8'hc3, 1'b1, KIND_EMPTY, 8'h00, 4'hf, 1'b1},
    {8'h80, 1'b0, NO_TYPED},
    {8'h01, 1'b0, NO_TYPED},
    {8'hff, 1'b1, KIND_DATA, 8'hff, 4'h0, 1'b1},
    // A ping is parsed like a data frame: masked, 16-bit length of two.
    {8'h89, 1'b0, NO_TYPED},
    {8'hfe, 1'b0, NO_TYPED},
    {8'h00, 1'b0, NO_TYPED},
    {8'h02, 1'b0, NO_TYPED},
    {8'h12, 1'b0, NO_TYPED},
    {8'h34, 1'b0, NO_TYPED},
    {8'h56, 1'b0, NO_TYPED},
    {8'h78, 1'b0, NO_TYPED},
    {8'haa, 1'b0, NO_TYPED},
    {8'h55, 1'b0, NO_TYPED}
  };

  logic clk = 1'b0;
  logic rst_n;

  wsfd_in_if in_if ();
  wsfd_out_if out_if ();

  websocket_frame_deframer_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser state as the block should hold it.
  phase_t      ph = PH_HEAD;
  logic [3:0]  op_held = '0;
  logic        masked = 1'b0;
  logic [3:0]  ext_left = '0;
  logic [63:0] remaining = '0;
  logic [31:0] key = '0;
  logic [1:0]  key_idx = '0;

  frame_result_t pending_results[$];
  int fail_count = 0;
  int bytes_sent = 0;
  int send_calm = 0;
  int recv_calm = 0;
  int cycle_count = 0;

  function automatic frame_result_t make_result(kind_t k, logic [7:0] p, logic [3:0] o,
                                                logic l);
    frame_result_t r;
    r.kind = k;
    r.payload = p;
    r.opcode = o;
    r.last = l;
    return r;
  endfunction

  task automatic finish_header(output bit got, output frame_result_t r);
    got = 1'b0;
    r = NO_TYPED;
    key_idx = '0;
    if (remaining == 0) begin
      ph = PH_HEAD;
      got = 1'b1;
      r = make_result(KIND_EMPTY, 8'h00, op_held, 1'b1);
    end else begin
      ph = PH_DATA;
    end
  endtask

  task automatic finish_length(output bit got, output frame_result_t r);
    got = 1'b0;
    r = NO_TYPED;
    if (masked) begin
      ph = PH_KEY;
      key_idx = '0;
    end else begin
      finish_header(got, r);
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b, output bit got, output frame_result_t r);
    logic [6:0] len7;
    logic [7:0] k;
    got = 1'b0;
    r = NO_TYPED;
    case (ph)
      PH_HEAD: begin
        if (b[7:4] != HDR_TOP) begin
          ph = PH_DEAD;
          got = 1'b1;
          r = make_result(KIND_BAD, 8'h00, b[3:0], 1'b1);
        end else if (b[3:0] == OP_CLOSE) begin
          ph = PH_DEAD;
          got = 1'b1;
          r = make_result(KIND_CLOSE, 8'h00, OP_CLOSE, 1'b1);
        end else begin
          op_held = b[3:0];
          ph = PH_LEN;
        end
      end
      PH_LEN: begin
        len7 = b[6:0];
        masked = b[7];
        if (len7 == LEN_EXT16 || len7 == LEN_EXT64) begin
          ext_left = (len7 == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
          remaining = '0;
          ph = PH_EXT;
        end else begin
          remaining = 64'(len7);
          finish_length(got, r);
        end
      end
      PH_EXT: begin
        remaining = {remaining[55:0], b};
        ext_left = ext_left - 4'd1;
        if (ext_left == 0) finish_length(got, r);
      end
      PH_KEY: begin
        key = {key[23:0], b};
        key_idx = key_idx + 2'd1;
        if (key_idx == 0) finish_header(got, r);
      end
      PH_DATA: begin
        k = masked ? key[8 * (3 - key_idx) +: 8] : 8'h00;
        key_idx = key_idx + 2'd1;
        remaining = remaining - 64'd1;
        got = 1'b1;
        r = make_result(KIND_DATA, b ^ k, op_held, remaining == 0);
        if (remaining == 0) ph = PH_HEAD;
      end
      default: begin
        // After an event every byte is swallowed.
      end
    endcase
  endtask

  // Presents one byte, holds it until the request is taken, then records what it should cause.
  task automatic push_byte(input logic [7:0] b, input bit use_typed,
                           input frame_result_t typed_r);
    int gap;
    bit got;
    frame_result_t r;
    if (send_calm > 0) begin
      send_calm--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 15);
      if ($urandom_range(0, 31) == 0) send_calm = $urandom_range(20, 80);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.rx_byte <= b;
    do @(posedge clk); while (!in_if.ready);
    deframe_byte(b, got, r);
    if (use_typed) r = typed_r;
    if (got || use_typed) pending_results.push_back(r);
    bytes_sent++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random stalls, compares each taken result with the oldest expectation.
  initial begin
    int gap;
    frame_result_t got_r;
    frame_result_t want_r;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (recv_calm > 0) begin
        recv_calm--;
        gap = 0;
      end else begin
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 31) == 0) recv_calm = $urandom_range(20, 80);
      end
      @(negedge clk);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      got_r = make_result(out_if.kind, out_if.payload_byte, out_if.frame_opcode, out_if.last);
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("ERROR: unexpected result kind %0d byte %02h opcode %0h last %0b",
                   got_r.kind, got_r.payload, got_r.opcode, got_r.last);
      end else begin
        want_r = pending_results.pop_front();
        if (got_r.kind !== want_r.kind || got_r.payload !== want_r.payload ||
            got_r.opcode !== want_r.opcode || got_r.last !== want_r.last) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: kind/byte/opcode/last expected %0d/%02h/%0h/%0b got %0d/%02h/%0h/%0b",
                     want_r.kind, want_r.payload, want_r.opcode, want_r.last,
                     got_r.kind, got_r.payload, got_r.opcode, got_r.last);
        end
      end
    end
  end

  initial begin
    int len;
    int cls;
    int tail;
    logic [3:0] op;
    logic mask;
    logic [7:0] b;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.rx_byte = 8'h00;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++)
      push_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);

    // Let the block drain completely before the random frames start.
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);

    while (bytes_sent < STREAM_BYTES) begin
      do op = 4'($urandom_range(0, 15)); while (op == OP_CLOSE);
      mask = 1'($urandom_range(0, 1));
      cls = $urandom_range(0, 9);
      push_byte({HDR_TOP, op}, 1'b0, NO_TYPED);
      if (cls <= 6) begin
        if (cls == 0) len = 0;
        else if (cls == 6) len = $urandom_range(17, 125);
        else len = $urandom_range(1, 16);
        push_byte({mask, 7'(len)}, 1'b0, NO_TYPED);
      end else if (cls <= 8) begin
        len = $urandom_range(0, 300);
        push_byte({mask, LEN_EXT16}, 1'b0, NO_TYPED);
        push_byte(8'(len >> 8), 1'b0, NO_TYPED);
        push_byte(8'(len), 1'b0, NO_TYPED);
      end else begin
        len = $urandom_range(0, 40);
        push_byte({mask, LEN_EXT64}, 1'b0, NO_TYPED);
        repeat (6) push_byte(8'h00, 1'b0, NO_TYPED);
        push_byte(8'(len >> 8), 1'b0, NO_TYPED);
        push_byte(8'(len), 1'b0, NO_TYPED);
      end
      if (mask) repeat (4) push_byte(8'($urandom_range(0, 255)), 1'b0, NO_TYPED);
      repeat (len) push_byte(8'($urandom_range(0, 255)), 1'b0, NO_TYPED);
    end

    // Only one terminal case fits in a run, since nothing but reset leaves it.
    tail = $urandom_range(0, 2);
    if (tail == 2) begin
      // Length with its top bit set: the frame never ends within the run.
      push_byte({HDR_TOP, op}, 1'b0, NO_TYPED);
      push_byte({mask, LEN_EXT64}, 1'b0, NO_TYPED);
      push_byte(8'($urandom_range(128, 255)), 1'b0, NO_TYPED);
      repeat (7) push_byte(8'($urandom_range(0, 255)), 1'b0, NO_TYPED);
      if (mask) repeat (4) push_byte(8'($urandom_range(0, 255)), 1'b0, NO_TYPED);
      repeat (40) push_byte(8'($urandom_range(0, 255)), 1'b0, NO_TYPED);
    end else begin
      if (tail == 0) begin
        do b = 8'($urandom_range(0, 255)); while (b[7:4] == HDR_TOP);
        push_byte(b, 1'b0, NO_TYPED);
      end else begin
        push_byte({HDR_TOP, OP_CLOSE}, 1'b0, NO_TYPED);
      end
      // A well-formed empty frame and noise afterwards must all be dropped.
      push_byte(8'h81, 1'b0, NO_TYPED);
      push_byte(8'h00, 1'b0, NO_TYPED);
      repeat (10) push_byte(8'($urandom_range(0, 255)), 1'b0, NO_TYPED);
    end

    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/wsfd_pkg.sv
rtl/wsfd_if.sv
rtl/websocket_frame_deframer_top.sv
sim/tb_websocket_frame_deframer_top.sv
